@@ sv/tlj_pkg.sv @@
// Package for the junction controller: request, result and state types,
// lamp and phase codes, register indexes and reset values.
// No dependencies.
package tlj_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int DUR_W              = 16;

  // Register indexes on the configuration channel.
  localparam logic [1:0] CFG_GREEN   = 2'd0;
  localparam logic [1:0] CFG_YELLOW  = 2'd1;
  localparam logic [1:0] CFG_ALL_RED = 2'd2;

  localparam logic [DUR_W-1:0] GREEN_RESET   = 16'd10000;
  localparam logic [DUR_W-1:0] YELLOW_RESET  = 16'd3000;
  localparam logic [DUR_W-1:0] ALL_RED_RESET = 16'd5000;

  // Road lamp codes.
  localparam logic [1:0] LAMP_RED    = 2'd0;
  localparam logic [1:0] LAMP_REDYEL = 2'd1;
  localparam logic [1:0] LAMP_GREEN  = 2'd2;
  localparam logic [1:0] LAMP_YELLOW = 2'd3;

  // Pedestrian lamp codes.
  localparam logic WALK_RED   = 1'b0;
  localparam logic WALK_GREEN = 1'b1;

  // Phase codes as seen on the result and held in last_served.
  localparam logic [1:0] CODE_ALL_RED = 2'd0;
  localparam logic [1:0] CODE_WALK    = 2'd1;
  localparam logic [1:0] CODE_MAIN    = 2'd2;
  localparam logic [1:0] CODE_CROSS   = 2'd3;
  localparam logic [1:0] CODE_NONE    = 2'd0;

  // Bits of the request latches.
  localparam int REQ_WALK  = 0;
  localparam int REQ_MAIN  = 1;
  localparam int REQ_CROSS = 2;

  typedef enum logic [3:0] {
    PH_ALL_RED = 4'b0001,
    PH_WALK    = 4'b0010,
    PH_MAIN    = 4'b0100,
    PH_CROSS   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic press_pedestrian;
    logic press_main;
    logic press_cross;
  } tick_t;

  typedef struct packed {
    logic [1:0] main_lamp;
    logic [1:0] cross_lamp;
    logic       walk_lamp;
    logic [1:0] phase;
    logic [2:0] pending;
  } lamps_t;

  typedef struct packed {
    logic [DUR_W-1:0] green_duration;
    logic [DUR_W-1:0] yellow_duration;
    logic [DUR_W-1:0] all_red_duration;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] lamp_step;
    logic [1:0] last_served;
    logic [2:0] requests;
    logic [1:0] main_state;
    logic [1:0] cross_state;
    logic       walk_state;
  } state_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_WALK:  code = CODE_WALK;
      PH_MAIN:  code = CODE_MAIN;
      PH_CROSS: code = CODE_CROSS;
      default:  code = CODE_ALL_RED;
    endcase
    return code;
  endfunction

endpackage

@@ sv/tlj_cfg.sv @@
// Timing register file of the junction controller, written over the
// configuration channel. Depends on tlj_pkg.
module tlj_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output tlj_pkg::cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_duration   <= tlj_pkg::GREEN_RESET;
      cfg.yellow_duration  <= tlj_pkg::YELLOW_RESET;
      cfg.all_red_duration <= tlj_pkg::ALL_RED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // An index past the last register is dropped.
      case (cfg_index)
        tlj_pkg::CFG_GREEN:   cfg.green_duration   <= cfg_data;
        tlj_pkg::CFG_YELLOW:  cfg.yellow_duration  <= cfg_data;
        tlj_pkg::CFG_ALL_RED: cfg.all_red_duration <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/tlj_step.sv @@
// Next-state logic of the junction controller for one tick: request
// latching, timer update and phase sequencing. Depends on tlj_pkg.
module tlj_step #(
  parameter int TIMER_BITS = tlj_pkg::TIMER_BITS_DEFAULT
) (
  input  tlj_pkg::state_t        st,
  input  logic [TIMER_BITS-1:0]  elapsed,
  input  tlj_pkg::tick_t         tick,
  input  tlj_pkg::cfg_t          cfg,
  output tlj_pkg::state_t        st_next,
  output logic [TIMER_BITS-1:0]  elapsed_next
);

  localparam int CMP_W = (TIMER_BITS > tlj_pkg::DUR_W) ? TIMER_BITS : tlj_pkg::DUR_W;

  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [CMP_W-1:0]      e_wide;
  logic                  over_green;
  logic                  over_yellow;
  logic                  over_all_red;
  tlj_pkg::phase_t       release_ph;
  logic [1:0]            road_lamp;
  logic                  road_change;
  logic                  road_done;
  logic                  is_main;

  // The timer stops at its top value rather than wrapping.
  assign elapsed_inc  = (elapsed == {TIMER_BITS{1'b1}}) ? elapsed
                                                        : elapsed + TIMER_BITS'(1);
  assign e_wide       = CMP_W'(elapsed_inc);
  assign over_green   = e_wide > CMP_W'(cfg.green_duration);
  assign over_yellow  = e_wide > CMP_W'(cfg.yellow_duration);
  assign over_all_red = e_wide > CMP_W'(cfg.all_red_duration);
  assign is_main      = (st.phase == tlj_pkg::PH_MAIN);

  always_comb begin
    st_next          = st;
    st_next.requests = st.requests | {tick.press_cross, tick.press_main,
                                      tick.press_pedestrian};
    elapsed_next     = elapsed_inc;
    release_ph       = tlj_pkg::PH_ALL_RED;
    road_lamp        = st.lamp_step;
    road_change      = 1'b0;
    road_done        = 1'b0;

    case (st.phase)
      tlj_pkg::PH_ALL_RED: begin
        // Requests in priority order, skipping whichever was served last;
        // otherwise a timed release alternating the two roads.
        if (st_next.requests[tlj_pkg::REQ_WALK] && st.last_served != tlj_pkg::CODE_WALK) begin
          release_ph = tlj_pkg::PH_WALK;
        end else if (st_next.requests[tlj_pkg::REQ_MAIN]
                     && st.last_served != tlj_pkg::CODE_MAIN) begin
          release_ph = tlj_pkg::PH_MAIN;
        end else if (st_next.requests[tlj_pkg::REQ_CROSS]
                     && st.last_served != tlj_pkg::CODE_CROSS) begin
          release_ph = tlj_pkg::PH_CROSS;
        end else if (over_all_red) begin
          release_ph = (st.last_served != tlj_pkg::CODE_MAIN) ? tlj_pkg::PH_MAIN
                                                               : tlj_pkg::PH_CROSS;
        end
        if (release_ph != tlj_pkg::PH_ALL_RED) begin
          st_next.phase       = release_ph;
          st_next.last_served = tlj_pkg::phase_code(release_ph);
          st_next.lamp_step   = tlj_pkg::LAMP_REDYEL;
          elapsed_next        = '0;
          case (release_ph)
            tlj_pkg::PH_WALK: st_next.walk_state  = tlj_pkg::WALK_GREEN;
            tlj_pkg::PH_MAIN: st_next.main_state  = tlj_pkg::LAMP_REDYEL;
            default:          st_next.cross_state = tlj_pkg::LAMP_REDYEL;
          endcase
        end
      end

      tlj_pkg::PH_WALK: begin
        if (st.lamp_step == tlj_pkg::LAMP_RED) begin
          st_next.lamp_step  = tlj_pkg::LAMP_REDYEL;
          st_next.walk_state = tlj_pkg::WALK_GREEN;
          elapsed_next       = '0;
        end else if (over_green) begin
          st_next.lamp_step                  = tlj_pkg::LAMP_RED;
          st_next.walk_state                 = tlj_pkg::WALK_RED;
          st_next.requests[tlj_pkg::REQ_WALK] = 1'b0;
          st_next.phase                      = tlj_pkg::PH_ALL_RED;
          elapsed_next                       = '0;
        end
      end

      tlj_pkg::PH_MAIN, tlj_pkg::PH_CROSS: begin
        case (st.lamp_step)
          tlj_pkg::LAMP_RED: begin
            road_lamp   = tlj_pkg::LAMP_REDYEL;
            road_change = 1'b1;
          end
          tlj_pkg::LAMP_REDYEL: begin
            road_lamp   = tlj_pkg::LAMP_GREEN;
            road_change = over_yellow;
          end
          tlj_pkg::LAMP_GREEN: begin
            road_lamp   = tlj_pkg::LAMP_YELLOW;
            road_change = over_green;
          end
          default: begin
            road_lamp   = tlj_pkg::LAMP_RED;
            road_change = over_yellow;
            road_done   = over_yellow;
          end
        endcase
        if (road_change) begin
          st_next.lamp_step = road_lamp;
          elapsed_next      = '0;
          if (is_main) begin
            st_next.main_state = road_lamp;
          end else begin
            st_next.cross_state = road_lamp;
          end
        end
        if (road_done) begin
          st_next.phase = tlj_pkg::PH_ALL_RED;
          if (is_main) begin
            st_next.requests[tlj_pkg::REQ_MAIN] = 1'b0;
          end else begin
            st_next.requests[tlj_pkg::REQ_CROSS] = 1'b0;
          end
        end
      end

      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

@@ sv/traffic_light_junction_controller.sv @@
// Top level of the junction controller: request register, controller
// state, result register and handshakes. Depends on tlj_pkg, tlj_cfg, tlj_step.
//
// Usage
// Each request on the tick channel (tick_valid, tick_stall, tick) is one
// millisecond tick carrying the pedestrian button and the two road detector
// bits. For every request accepted, exactly one result comes out on the
// lamps channel (lamps_valid, lamps_stall, lamps): both road lamps, the
// pedestrian lamp, the current phase and the request latches, all as they
// stand after that tick.
// A request is first held in the request register; the controller state and
// the result register are then updated together when it moves on, which
// waits while the result register is blocked. One request is taken in every
// cycle while the receiver takes results; the state update bounds this.
// When the receiver stalls, the result holds and the request register fills;
// tick_stall then rises until the result is taken, so nothing is dropped.
// The timing registers (green, yellow, all-red) are written over the cfg
// channel, which is always ready; write them only while the block is idle.
// Reset (rst, synchronous) puts all lamps to red in the all-red phase with
// no requests latched, clears the timer and restores the default timings.
module traffic_light_junction_controller #(
  parameter int TIMER_BITS = tlj_pkg::TIMER_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_valid,
  output logic             tick_stall,
  input  tlj_pkg::tick_t   tick,
  output logic             lamps_valid,
  input  logic             lamps_stall,
  output tlj_pkg::lamps_t  lamps,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  tlj_pkg::cfg_t         cfg;
  tlj_pkg::tick_t        tick_q;
  logic                  tick_q_valid;
  tlj_pkg::state_t       st;
  tlj_pkg::state_t       st_next;
  logic [TIMER_BITS-1:0] elapsed;
  logic [TIMER_BITS-1:0] elapsed_next;
  logic                  result_free;
  logic                  advance;
  logic                  tick_accept;

  tlj_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlj_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .st           (st),
    .elapsed      (elapsed),
    .tick         (tick_q),
    .cfg          (cfg),
    .st_next      (st_next),
    .elapsed_next (elapsed_next)
  );

  // The result register is free when empty or being taken this cycle; the
  // registered request moves into the controller whenever it is.
  assign result_free = !lamps_valid || !lamps_stall;
  assign advance     = tick_q_valid && result_free;
  assign tick_stall  = tick_q_valid && !result_free;
  assign tick_accept = tick_valid && !tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
    end else if (tick_accept) begin
      tick_q_valid <= 1'b1;
    end else if (advance) begin
      tick_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      tick_q <= tick;
    end
  end

  // Controller state moves once per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= tlj_pkg::PH_ALL_RED;
      st.lamp_step   <= tlj_pkg::LAMP_RED;
      st.last_served <= tlj_pkg::CODE_NONE;
      st.requests    <= '0;
      st.main_state  <= tlj_pkg::LAMP_RED;
      st.cross_state <= tlj_pkg::LAMP_RED;
      st.walk_state  <= tlj_pkg::WALK_RED;
      elapsed        <= '0;
    end else if (advance) begin
      st      <= st_next;
      elapsed <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lamps_valid <= 1'b0;
    end else if (advance) begin
      lamps_valid <= 1'b1;
    end else if (!lamps_stall) begin
      lamps_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lamps.main_lamp  <= st_next.main_state;
      lamps.cross_lamp <= st_next.cross_state;
      lamps.walk_lamp  <= st_next.walk_state;
      lamps.phase      <= tlj_pkg::phase_code(st_next.phase);
      lamps.pending    <= st_next.requests;
    end
  end

  // In all red nothing may show anything but red.
  a_all_red_lamps: assert property (@(posedge clk) disable iff (rst)
    st.phase == tlj_pkg::PH_ALL_RED |->
      st.main_state == tlj_pkg::LAMP_RED && st.cross_state == tlj_pkg::LAMP_RED
      && st.walk_state == tlj_pkg::WALK_RED)
    else $error("lamp lit during all red");

  // Pedestrians walk only against two red roads.
  a_walk_safe: assert property (@(posedge clk) disable iff (rst)
    st.walk_state == tlj_pkg::WALK_GREEN |->
      st.phase == tlj_pkg::PH_WALK && st.main_state == tlj_pkg::LAMP_RED
      && st.cross_state == tlj_pkg::LAMP_RED)
    else $error("pedestrian green with conflicting traffic");

  // The two roads never show anything but red at the same time.
  a_roads_exclusive: assert property (@(posedge clk) disable iff (rst)
    st.main_state != tlj_pkg::LAMP_RED |-> st.cross_state == tlj_pkg::LAMP_RED)
    else $error("main and cross road both released");

  // A request moved into the controller always yields a result next cycle.
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> lamps_valid)
    else $error("request processed without a result");

  // A held request is not lost while the result register is blocked.
  a_request_held: assert property (@(posedge clk) disable iff (rst)
    tick_q_valid && !result_free |=> tick_q_valid && $stable(tick_q))
    else $error("held request lost or changed");

endmodule

@@ tb/sv/tb_traffic_light_junction_controller.sv @@
// Self-checking testbench for traffic_light_junction_controller: drives ticks and
// timing writes, predicts every lamps result and compares it field by field.
// Depends on tlj_pkg and the controller RTL only.
module tb_traffic_light_junction_controller;

  // The controller is built with an 8-bit timer, so that the
  // timer saturates within a few hundred ticks and timings above its range
  // can be seen holding a phase until they are lowered again.
  localparam int TB_TIMER_BITS = 8;
  localparam logic [TB_TIMER_BITS-1:0] TIMER_FULL = '1;
  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD = 60;
  // The configuration index field has one code beyond the three registers.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            tick_valid = 1'b0;
  logic            tick_stall;
  tlj_pkg::tick_t  tick = '0;
  logic            lamps_valid;
  logic            lamps_stall = 1'b0;
  tlj_pkg::lamps_t lamps;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [1:0]      cfg_index = tlj_pkg::CFG_GREEN;
  logic [15:0]     cfg_data = '0;

  traffic_light_junction_controller #(
    .TIMER_BITS(TB_TIMER_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick(tick),
    .lamps_valid(lamps_valid),
    .lamps_stall(lamps_stall),
    .lamps(lamps),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Ticks waiting to be offered, and the lamps results predicted for the
  // ticks that the controller has already accepted, oldest first.
  tlj_pkg::tick_t  tick_queue[$];
  tlj_pkg::lamps_t lamp_queue[$];

  // Idling rates in percent for each side, and the length of a long
  // receiver hold-off still to run.
  int tx_idle_pct = 32;
  int rx_idle_pct = 58;
  int hold_left = 0;

  int              mismatches = 0;
  int              ticks_sent = 0;
  int              results_checked = 0;
  int              walks_served = 0;
  int              mains_served = 0;
  int              crosses_served = 0;
  logic            tick_taken = 1'b0;
  tlj_pkg::lamps_t predicted;
  tlj_pkg::lamps_t want_lamps;

  // Our own copy of the controller: timing registers and junction state.
  logic [15:0]              green_q = tlj_pkg::GREEN_RESET;
  logic [15:0]              yellow_q = tlj_pkg::YELLOW_RESET;
  logic [15:0]              all_red_q = tlj_pkg::ALL_RED_RESET;
  logic [1:0]               phase_q = tlj_pkg::CODE_ALL_RED;
  logic [1:0]               step_q = tlj_pkg::LAMP_RED;
  logic [TB_TIMER_BITS-1:0] elapsed_q = '0;
  logic [1:0]               served_q = tlj_pkg::CODE_NONE;
  logic [2:0]               pending_q = '0;
  logic [1:0]               main_q = tlj_pkg::LAMP_RED;
  logic [1:0]               cross_q = tlj_pkg::LAMP_RED;
  logic                     walk_q = tlj_pkg::WALK_RED;

  task automatic show_road_lamp(input logic [1:0] road, input logic [1:0] lamp);
    if (road == tlj_pkg::CODE_MAIN) begin
      main_q = lamp;
    end else begin
      cross_q = lamp;
    end
  endtask

  // Advances the junction by one tick and returns the lamps as they stand
  // after it. Presses are latched first, so a press in the very tick that
  // clears its latch is lost.
  task automatic advance_controller(input tlj_pkg::tick_t t, output tlj_pkg::lamps_t res);
    logic [1:0] release_to;
    release_to = tlj_pkg::CODE_ALL_RED;
    pending_q = pending_q | {t.press_cross, t.press_main, t.press_pedestrian};
    if (elapsed_q != TIMER_FULL) begin
      elapsed_q = elapsed_q + 1'b1;
    end
    case (phase_q)
      tlj_pkg::CODE_ALL_RED: begin
        // Pedestrians first, then main, then cross, never the one served
        // last; with nothing usable and all-red time exceeded, alternate.
        if (pending_q[tlj_pkg::REQ_WALK] && served_q != tlj_pkg::CODE_WALK) begin
          release_to = tlj_pkg::CODE_WALK;
        end else if (pending_q[tlj_pkg::REQ_MAIN] && served_q != tlj_pkg::CODE_MAIN) begin
          release_to = tlj_pkg::CODE_MAIN;
        end else if (pending_q[tlj_pkg::REQ_CROSS] && served_q != tlj_pkg::CODE_CROSS) begin
          release_to = tlj_pkg::CODE_CROSS;
        end else if (elapsed_q > all_red_q) begin
          release_to = (served_q != tlj_pkg::CODE_MAIN) ? tlj_pkg::CODE_MAIN
                                                        : tlj_pkg::CODE_CROSS;
        end
        if (release_to == tlj_pkg::CODE_WALK) begin
          step_q = {1'b0, tlj_pkg::WALK_GREEN};
          walk_q = tlj_pkg::WALK_GREEN;
          walks_served++;
        end else if (release_to != tlj_pkg::CODE_ALL_RED) begin
          step_q = tlj_pkg::LAMP_REDYEL;
          show_road_lamp(release_to, tlj_pkg::LAMP_REDYEL);
          if (release_to == tlj_pkg::CODE_MAIN) begin
            mains_served++;
          end else begin
            crosses_served++;
          end
        end
        if (release_to != tlj_pkg::CODE_ALL_RED) begin
          phase_q = release_to;
          served_q = release_to;
          elapsed_q = '0;
        end
      end
      tlj_pkg::CODE_WALK: begin
        // A red step inside the pedestrian phase counts as its first step;
        // any step above red counts as green.
        if (step_q == tlj_pkg::LAMP_RED) begin
          step_q = {1'b0, tlj_pkg::WALK_GREEN};
          walk_q = tlj_pkg::WALK_GREEN;
          elapsed_q = '0;
        end else if (elapsed_q > green_q) begin
          step_q = tlj_pkg::LAMP_RED;
          walk_q = tlj_pkg::WALK_RED;
          pending_q[tlj_pkg::REQ_WALK] = 1'b0;
          phase_q = tlj_pkg::CODE_ALL_RED;
          elapsed_q = '0;
        end
      end
      default: begin
        case (step_q)
          tlj_pkg::LAMP_RED: begin
            step_q = tlj_pkg::LAMP_REDYEL;
            show_road_lamp(phase_q, tlj_pkg::LAMP_REDYEL);
            elapsed_q = '0;
          end
          tlj_pkg::LAMP_REDYEL: begin
            if (elapsed_q > yellow_q) begin
              step_q = tlj_pkg::LAMP_GREEN;
              show_road_lamp(phase_q, tlj_pkg::LAMP_GREEN);
              elapsed_q = '0;
            end
          end
          tlj_pkg::LAMP_GREEN: begin
            if (elapsed_q > green_q) begin
              step_q = tlj_pkg::LAMP_YELLOW;
              show_road_lamp(phase_q, tlj_pkg::LAMP_YELLOW);
              elapsed_q = '0;
            end
          end
          default: begin
            if (elapsed_q > yellow_q) begin
              step_q = tlj_pkg::LAMP_RED;
              show_road_lamp(phase_q, tlj_pkg::LAMP_RED);
              if (phase_q == tlj_pkg::CODE_MAIN) begin
                pending_q[tlj_pkg::REQ_MAIN] = 1'b0;
              end else begin
                pending_q[tlj_pkg::REQ_CROSS] = 1'b0;
              end
              phase_q = tlj_pkg::CODE_ALL_RED;
              elapsed_q = '0;
            end
          end
        endcase
      end
    endcase
    res.main_lamp = main_q;
    res.cross_lamp = cross_q;
    res.walk_lamp = walk_q;
    res.phase = phase_q;
    res.pending = pending_q;
  endtask

  // Tick driver. Acceptance is seen at the rising edge, where the predicted
  // result is queued; the next request is put up at the falling edge.
  always @(posedge clk) begin
    if (!rst && tick_valid && !tick_stall) begin
      advance_controller(tick, predicted);
      lamp_queue.push_back(predicted);
      ticks_sent++;
      tick_taken = 1'b1;
    end else begin
      tick_taken = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!tick_valid || tick_taken) begin
      // A request still waiting is held unchanged; otherwise the next one
      // goes up unless the sender chooses to idle this cycle.
      if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        tick <= tick_queue.pop_front();
        tick_valid <= 1'b1;
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // Receiver. A long hold-off, when armed, is counted down here before
  // random stalling resumes.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      lamps_stall <= 1'b1;
      hold_left--;
    end else begin
      lamps_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Result checker: every accepted result is matched against the oldest
  // prediction still outstanding.
  always @(posedge clk) begin
    if (!rst && lamps_valid && !lamps_stall) begin
      results_checked++;
      if (lamp_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected lamps result %0d with no tick outstanding: %p",
                   results_checked, lamps);
        end
      end else begin
        want_lamps = lamp_queue.pop_front();
        if (lamps.main_lamp !== want_lamps.main_lamp ||
            lamps.cross_lamp !== want_lamps.cross_lamp ||
            lamps.walk_lamp !== want_lamps.walk_lamp ||
            lamps.phase !== want_lamps.phase ||
            lamps.pending !== want_lamps.pending) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display({"lamps result %0d wrong: expected main=%0d cross=%0d",
                      " walk=%0d phase=%0d pending=%b"},
                     results_checked, want_lamps.main_lamp, want_lamps.cross_lamp,
                     want_lamps.walk_lamp, want_lamps.phase, want_lamps.pending);
            $display("  got main=%0d cross=%0d walk=%0d phase=%0d pending=%b",
                     lamps.main_lamp, lamps.cross_lamp, lamps.walk_lamp,
                     lamps.phase, lamps.pending);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no handshake of any kind completes for too
  // long, which covers a hung controller as well as lost results.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((tick_valid && !tick_stall) || (lamps_valid && !lamps_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  task automatic push_tick(input logic ped, input logic road_main, input logic road_cross);
    tlj_pkg::tick_t t;
    t.press_pedestrian = ped;
    t.press_main = road_main;
    t.press_cross = road_cross;
    tick_queue.push_back(t);
  endtask

  // Waits until every tick has been taken and every result has arrived,
  // then lets the pipeline settle before anything else is touched.
  task automatic wait_for_drain();
    do @(negedge clk); while (tick_queue.size() != 0 || tick_valid || lamp_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write; our copy of the register follows once the write
  // has been taken.
  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tlj_pkg::CFG_GREEN: green_q = value;
      tlj_pkg::CFG_YELLOW: yellow_q = value;
      tlj_pkg::CFG_ALL_RED: all_red_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_timings(input logic [15:0] green, input logic [15:0] yellow,
                                 input logic [15:0] all_red);
    write_register(tlj_pkg::CFG_GREEN, green);
    write_register(tlj_pkg::CFG_YELLOW, yellow);
    write_register(tlj_pkg::CFG_ALL_RED, all_red);
  endtask

  // Drains, retimes the junction, then queues a block of random ticks in
  // which each button is pressed with the given chance.
  task automatic run_random_phase(input logic [15:0] green, input logic [15:0] yellow,
                                  input logic [15:0] all_red, input int count,
                                  input int press_pct, input int tx_pct, input int rx_pct);
    wait_for_drain();
    program_timings(green, yellow, all_red);
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      push_tick($urandom_range(99) < press_pct, $urandom_range(99) < press_pct,
                $urandom_range(99) < press_pct);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset timings: with the narrow timer they are never exceeded, so the
    // pedestrian phase, released first when all three buttons are pressed
    // together, stays green until the timings are lowered.
    @(posedge clk);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    wait_for_drain();

    // Zero timings: every timed step advances on the next tick. The main
    // and cross presses below fall on the ticks that clear those latches
    // and so are lost; the empty stretches give timed releases that
    // alternate between the roads. The spare index must change nothing.
    program_timings('0, '0, '0);
    write_register(CFG_SPARE, 16'hFFFF);
    @(posedge clk);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    for (int i = 0; i < 5; i++) begin
      push_tick(1'b0, 1'b0, 1'b0);
    end
    push_tick(1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) begin
      push_tick(1'b0, 1'b0, 1'b0);
    end

    // Short timings with the sender idling less than the receiver. Right
    // after queuing, the receiver holds off long enough for the controller
    // to fill up and stall its tick input while ticks keep being offered.
    run_random_phase(16'd3, 16'd1, 16'd2, 200, 15, 32, 58);
    hold_left = LONG_HOLD;
    // Full-scale timings: only requests release anything, the first road
    // released then sits in red-yellow while its timer saturates.
    run_random_phase('1, '1, '1, 300, 2, 32, 58);
    // Back to zero, which lets the held road move on; idling swapped.
    run_random_phase('0, '0, '0, 150, 20, 58, 32);
    run_random_phase(16'($urandom_range(20)), 16'($urandom_range(20)),
                     16'($urandom_range(20)), 150, 10, 58, 32);
    // Green just below the saturated timer, all-red above it; no idling.
    run_random_phase(16'd254, 16'd7, 16'd300, 150, 5, 0, 0);
    run_random_phase(16'($urandom_range(40)), 16'($urandom_range(40)),
                     16'($urandom_range(40)), 150, 10, 0, 0);
    wait_for_drain();

    $display({"Checked %0d lamps results for %0d ticks under eight timing settings,",
              " zero and full scale among them."},
             results_checked, ticks_sent);
    $display("Phases released: %0d pedestrian, %0d main road, %0d cross road.",
             walks_served, mains_served, crosses_served);
    if (mismatches == 0 && lamp_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
